/* sv/lnod_pkg.sv */
package lnod_pkg;

  // Field widths
  localparam int RANGE_W    = 16;
  localparam int ANGLE_FRAC = 14;
  localparam int ANGLE_W    = ANGLE_FRAC + 3;
  // Quotient width of the deflection magnitude (3*pi/4 stays below 2^(ANGLE_FRAC+2))
  localparam int Q_W        = ANGLE_FRAC + 2;
  // Working width for angle sums before wrapping
  localparam int AX_W       = ANGLE_W + 2;

  // Angle constants in units of 2^-ANGLE_FRAC rad
  localparam longint PI_FX      = ((64'd31416 << ANGLE_FRAC) + 64'd5000) / 64'd10000;
  localparam longint TAU_FX     = 2 * PI_FX;
  localparam longint HALF_PI_FX = PI_FX / 2;
  localparam longint DEFL_FX    = (3 * PI_FX) / 4;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int THRESHOLD_RST = 1000;

  // Queue between the scan front and the deflection back
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    REG_ANGLE_START = 3'd0,
    REG_ANGLE_INCR  = 3'd1,
    REG_RANGE_LOWER = 3'd2,
    REG_RANGE_UPPER = 3'd3,
    REG_THRESHOLD   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_start;
    logic signed [ANGLE_W-1:0] angle_incr;
    logic [RANGE_W-1:0]        range_lower;
    logic [RANGE_W-1:0]        range_upper;
    logic [RANGE_W-1:0]        deflect_threshold;
  } cfg_t;

  // Outcome of one scan, handed from front to back
  typedef struct packed {
    logic                      found;
    logic [RANGE_W-1:0]        range;
    logic signed [ANGLE_W-1:0] angle;
  } scan_sum_t;

endpackage

/* sv/lidar_nearest_obstacle_deflection.sv */
// Channel   Handshake             Word
// in        in_valid / in_stall   sample_range, sample_bad, last_of_scan
// out       out_valid / out_stall obstacle_found, nearest_range, nearest_angle,
//                                 steer_deflection
// config    APB psel/penable      angle_start, angle_incr, range_lower,
//                                 range_upper, deflect_threshold
//
// Samples enter one a cycle; a two-stage front updates the beam angle and then the
// nearest-obstacle search. A finished scan waits in a short queue for the back,
// which takes one scan at a time through two multiply steps and a restoring divider
// producing one quotient bit a cycle. The front stalls only when a scan ends while
// the queue is full. Reset is synchronous and clears all control state.
module lidar_nearest_obstacle_deflection #(
  parameter int QUEUE_DEPTH = lnod_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lnod_pkg::ADDR_W-1:0]         paddr,
  input  logic [lnod_pkg::DATA_W-1:0]         pwdata,
  output logic [lnod_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lnod_pkg::RANGE_W-1:0]        sample_range,
  input  logic                                sample_bad,
  input  logic                                last_of_scan,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                obstacle_found,
  output logic [lnod_pkg::RANGE_W-1:0]        nearest_range,
  output logic signed [lnod_pkg::ANGLE_W-1:0] nearest_angle,
  output logic signed [lnod_pkg::ANGLE_W-1:0] steer_deflection
);
  import lnod_pkg::*;

  cfg_t      cfg;
  reg_idx_t  reg_idx;
  logic      wr_en;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  scan_sum_t push_data;
  scan_sum_t pop_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_start       <= '0;
      cfg.angle_incr        <= '0;
      cfg.range_lower       <= '0;
      cfg.range_upper       <= '1;
      cfg.deflect_threshold <= RANGE_W'(THRESHOLD_RST);
    end else if (wr_en) begin
      case (reg_idx)
        REG_ANGLE_START: cfg.angle_start       <= pwdata[ANGLE_W-1:0];
        REG_ANGLE_INCR:  cfg.angle_incr        <= pwdata[ANGLE_W-1:0];
        REG_RANGE_LOWER: cfg.range_lower       <= pwdata[RANGE_W-1:0];
        REG_RANGE_UPPER: cfg.range_upper       <= pwdata[RANGE_W-1:0];
        REG_THRESHOLD:   cfg.deflect_threshold <= pwdata[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads, angles sign-extended
  always_comb begin
    unique case (reg_idx)
      REG_ANGLE_START: prdata = DATA_W'(cfg.angle_start);
      REG_ANGLE_INCR:  prdata = DATA_W'(cfg.angle_incr);
      REG_RANGE_LOWER: prdata = DATA_W'(cfg.range_lower);
      REG_RANGE_UPPER: prdata = DATA_W'(cfg.range_upper);
      REG_THRESHOLD:   prdata = DATA_W'(cfg.deflect_threshold);
      default:         prdata = '0;
    endcase
  end

  lnod_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_range (sample_range),
    .sample_bad   (sample_bad),
    .last_of_scan (last_of_scan),
    .full         (full),
    .push         (push),
    .push_data    (push_data)
  );

  lnod_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  lnod_back u_back (
    .clk              (clk),
    .rst              (rst),
    .threshold        (cfg.deflect_threshold),
    .empty            (empty),
    .pop              (pop),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .obstacle_found   (obstacle_found),
    .nearest_range    (nearest_range),
    .nearest_angle    (nearest_angle),
    .steer_deflection (steer_deflection)
  );

endmodule

/* sv/lnod_front.sv */
module lnod_front (
  input  logic                       clk,
  input  logic                       rst,
  input  lnod_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lnod_pkg::RANGE_W-1:0] sample_range,
  input  logic                       sample_bad,
  input  logic                       last_of_scan,
  input  logic                       full,
  output logic                       push,
  output lnod_pkg::scan_sum_t        push_data
);
  import lnod_pkg::*;

  localparam logic signed [AX_W-1:0] PI_AX   = AX_W'(PI_FX);
  localparam logic signed [AX_W-1:0] TAU_AX  = AX_W'(TAU_FX);
  localparam logic signed [AX_W-1:0] HALF_AX = AX_W'(HALF_PI_FX);

  // Stage A: beam angle and the held word
  logic                      scan_start;
  logic signed [ANGLE_W-1:0] running_angle;
  logic                      a_valid;
  logic [RANGE_W-1:0]        a_range;
  logic                      a_bad;
  logic                      a_last;

  // Stage B: best sample so far
  logic                      best_valid;
  logic [RANGE_W-1:0]        best_range;
  logic signed [ANGLE_W-1:0] best_angle;

  logic                      advance;
  logic                      accept;
  logic signed [AX_W-1:0]    ang_sum;
  logic signed [AX_W-1:0]    ang_wrap;
  logic signed [AX_W-1:0]    refl_x;
  logic                      hit;
  logic                      take;
  logic                      best_valid_next;
  logic [RANGE_W-1:0]        best_range_next;
  logic signed [ANGLE_W-1:0] best_angle_next;

  // Hold everything while a finished scan cannot enter the queue
  assign advance  = !(a_valid && a_last && full);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Next beam angle, wrapped into [-pi, pi)
  always_comb begin
    if (scan_start) begin
      ang_sum = AX_W'(cfg.angle_start);
    end else begin
      ang_sum = AX_W'(running_angle) + AX_W'(cfg.angle_incr);
    end
    if (ang_sum < -PI_AX) begin
      ang_wrap = ang_sum + TAU_AX;
    end else if (ang_sum >= PI_AX) begin
      ang_wrap = ang_sum - TAU_AX;
    end else begin
      ang_wrap = ang_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      scan_start    <= 1'b1;
      running_angle <= '0;
    end else if (advance) begin
      a_valid <= in_valid;
      if (in_valid) begin
        running_angle <= ang_wrap[ANGLE_W-1:0];
        scan_start    <= last_of_scan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_range <= sample_range;
      a_bad   <= sample_bad;
      a_last  <= last_of_scan;
    end
  end

  // Reflected angle: a - pi for a positive beam, a + pi otherwise
  always_comb begin
    if (running_angle > 0) begin
      refl_x = AX_W'(running_angle) - PI_AX;
    end else begin
      refl_x = AX_W'(running_angle) + PI_AX;
    end
  end

  // Classify the sample and keep the first strictly smallest range
  assign hit = !a_bad && (a_range >= cfg.range_lower) && (a_range <= cfg.range_upper)
               && (refl_x >= -HALF_AX) && (refl_x <= HALF_AX);
  assign take = hit && (!best_valid || (a_range < best_range));

  always_comb begin
    best_valid_next = best_valid;
    best_range_next = best_range;
    best_angle_next = best_angle;
    if (take) begin
      best_valid_next = 1'b1;
      best_range_next = a_range;
      best_angle_next = refl_x[ANGLE_W-1:0];
    end
  end

  assign push            = a_valid && a_last && advance;
  assign push_data.found = best_valid_next;
  assign push_data.range = best_range_next;
  assign push_data.angle = best_angle_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_range <= '1;
      best_angle <= '0;
    end else if (a_valid && advance) begin
      if (a_last) begin
        best_valid <= 1'b0;
        best_range <= '1;
        best_angle <= '0;
      end else begin
        best_valid <= best_valid_next;
        best_range <= best_range_next;
        best_angle <= best_angle_next;
      end
    end
  end

endmodule

/* sv/lnod_queue.sv */
module lnod_queue #(
  parameter int DEPTH = lnod_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lnod_pkg::scan_sum_t push_data,
  input  logic                pop,
  output lnod_pkg::scan_sum_t pop_data,
  output logic                full,
  output logic                empty
);
  import lnod_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  scan_sum_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   rd_ptr_next;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  assign rd_ptr_next = !do_pop ? rd_ptr :
                       (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Read the head word ahead, passing through a word written into that slot
  always_ff @(posedge clk) begin
    if (do_push && (wr_ptr == rd_ptr_next)) begin
      pop_data <= push_data;
    end else begin
      pop_data <= mem[rd_ptr_next];
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/lnod_back.sv */
module lnod_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lnod_pkg::RANGE_W-1:0] threshold,
  input  logic                         empty,
  output logic                         pop,
  input  lnod_pkg::scan_sum_t          pop_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         obstacle_found,
  output logic [lnod_pkg::RANGE_W-1:0] nearest_range,
  output logic signed [lnod_pkg::ANGLE_W-1:0] nearest_angle,
  output logic signed [lnod_pkg::ANGLE_W-1:0] steer_deflection
);
  import lnod_pkg::*;

  localparam int SQ_W  = 2 * RANGE_W;
  localparam int NW    = SQ_W + Q_W;
  localparam int CNT_W = $clog2(Q_W);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQUARE = 5'b00010,
    ST_SCALE  = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t             state;
  scan_sum_t          cur;
  logic               apply;
  logic [SQ_W-1:0]    dd;
  logic [SQ_W-1:0]    den;
  logic [NW-1:0]      rem;
  logic [NW-1:0]      dsh;
  logic [Q_W-1:0]     quo;
  logic [CNT_W-1:0]   cnt;
  logic [RANGE_W-1:0] diff;
  logic               out_free;
  logic               load;
  logic signed [ANGLE_W-1:0] defl;

  assign pop      = (state == ST_IDLE) && !empty;
  assign diff     = threshold - cur.range;
  assign out_free = !out_valid || !out_stall;
  assign load     = (state == ST_DONE) && out_free;

  // Signed deflection, sign opposite to the angle
  always_comb begin
    if (!apply) begin
      defl = '0;
    end else if (cur.angle >= 0) begin
      defl = -$signed({1'b0, quo});
    end else begin
      defl = $signed({1'b0, quo});
    end
  end

  // Sequence: square, scale, restoring divide one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            cur   <= pop_data;
            apply <= pop_data.found && (threshold != '0) && (pop_data.range <= threshold);
            state <= (pop_data.found && (threshold != '0) && (pop_data.range <= threshold))
                     ? ST_SQUARE : ST_DONE;
          end
        end
        ST_SQUARE: begin
          dd    <= SQ_W'(diff) * SQ_W'(diff);
          den   <= SQ_W'(threshold) * SQ_W'(threshold);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          rem   <= NW'(dd) * NW'(DEFL_FX) + NW'(den >> 1);
          dsh   <= NW'(den) << (Q_W - 1);
          quo   <= '0;
          cnt   <= '0;
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[Q_W-2:0], 1'b1};
          end else begin
            quo <= {quo[Q_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(Q_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obstacle_found   <= cur.found;
      nearest_range    <= cur.range;
      nearest_angle    <= cur.angle;
      steer_deflection <= defl;
    end
  end

endmodule
